// ===== rtl/core/plrg_pkg.sv =====
// Package for the piecewise linear ramp generator.
// Holds field widths, op and register codes, payload words and the
// controller/datapath command and status structs. Depends on nothing.
`timescale 1ns / 1ps

package plrg_pkg;

  // Field widths fixed by the interface.
  localparam int VALUE_BITS     = 16;
  localparam int TICK_BITS      = 16;
  localparam int COUNT_BITS     = 11;
  localparam int INDEX_BITS     = 10;
  localparam int OP_BITS        = 2;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // Default table depth.
  localparam int MAX_POINTS_DEFAULT = 1024;

  // Divider step counter must hold VALUE_BITS itself.
  localparam int DIV_CNT_BITS = $clog2(VALUE_BITS + 1);

  // Reset value of the ticks-per-segment register.
  localparam logic [TICK_BITS-1:0] DELTA_TICKS_RESET = TICK_BITS'(1);

  // Op codes of an input word.
  localparam logic [OP_BITS-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_RESTART = 2'd1;
  localparam logic [OP_BITS-1:0] OP_TICK    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_DELTA_TICKS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_POINTS  = 2'd1;

  // Input word.
  typedef struct packed {
    logic [OP_BITS-1:0]           op;
    logic [INDEX_BITS-1:0]        point_index;
    logic signed [VALUE_BITS-1:0] point_value;
  } in_word_t;

  // Output word.
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         active;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // write the breakpoint of the accepted word
    logic restart;     // clear segment and tick counters
    logic pre_adjust;  // roll over a stale tick count before computing
    logic sel_zero;    // disabled: result is zero, inactive
    logic rd_seg;      // read the segment start point
    logic rd_next;     // read the segment stop point
    logic rd_last;     // read the final point
    logic cap_start;   // latch the start point from the memory
    logic cap_diff;    // latch sign and magnitude of stop - start
    logic mul;         // multiply by the tick count, advance counters
    logic div_step;    // one restoring division step
    logic finish;      // form start +/- quotient
    logic cap_last;    // result is the final point, inactive
    logic out_load;    // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic disabled;    // num_points or delta_ticks is zero
    logic running;     // segment index is before the last point
    logic div_done;    // all quotient bits produced
    logic out_free;    // output register can take a word this cycle
  } status_t;

endpackage

// ===== rtl/core/piecewise_linear_ramp_generator.sv =====
// Piecewise linear ramp generator: breakpoint table, segment interpolation.
// Top level joining the controller and the datapath.
// Depends on plrg_pkg, plrg_ctrl, plrg_datapath.
//
// Usage:
//   in channel (in_valid, in_stall, in_word): a load word writes one
//   breakpoint, a restart word clears the segment and tick counters, and a
//   tick word produces one output word. Load and restart words produce no
//   output.
//   out channel (out_valid, out_stall, out_word): value and active flag.
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 is
//   delta_ticks, index 1 is num_points; cfg_ready is always high. Write it
//   only while no tick is in flight.
//   Sequence: a running tick reads the segment points, multiplies, runs
//   the 16-step restoring divider and forms the sum before its word is
//   loaded; the next input word is taken after that load. A tick past the
//   last point reads the final point only, and one while disabled gives zero.
//   Reset: counters clear, delta_ticks is 1, num_points is 0, and no word
//   is pending. The breakpoint table holds nothing until loaded.
//   Stall: the output register holds its word; a finished tick waits for
//   it to free while in_stall stays high, but load and restart words are
//   still taken while an earlier word waits to be taken.
`timescale 1ns / 1ps

module piecewise_linear_ramp_generator #(
  parameter int MAX_POINTS = plrg_pkg::MAX_POINTS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  plrg_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output plrg_pkg::out_word_t                 out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [plrg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [plrg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  plrg_pkg::cmd_t    cmd;
  plrg_pkg::status_t status;

  // Registers are plain flops; a write is always taken.
  assign cfg_ready = 1'b1;

  // Controller.
  plrg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_word.op),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  plrg_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_word   (in_word),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== rtl/core/plrg_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module plrg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/plrg_ctrl.sv =====
// Controller state machine for the piecewise linear ramp generator.
// Sequences table reads, multiply, divide and output hand-off.
// Depends on plrg_pkg.
`timescale 1ns / 1ps

module plrg_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [plrg_pkg::OP_BITS-1:0]      in_op,
  output logic                              in_stall,
  input  plrg_pkg::status_t                 status,
  output plrg_pkg::cmd_t                    cmd
);

  typedef enum logic [3:0] {
    IDLE,
    DECIDE,
    RD_NEXT,
    DIFF,
    MUL,
    DIV,
    FIN,
    LAST,
    OUT
  } state_t;

  state_t state;
  state_t state_next;

  // Input words are taken only between ticks.
  assign in_stall = (state != IDLE);

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          case (in_op)
            plrg_pkg::OP_LOAD: begin
              cmd.load = 1'b1;
            end
            plrg_pkg::OP_RESTART: begin
              cmd.restart = 1'b1;
            end
            plrg_pkg::OP_TICK: begin
              cmd.pre_adjust = 1'b1;
              state_next     = DECIDE;
            end
            default: begin
              // Unused code: the word is dropped.
            end
          endcase
        end
      end
      DECIDE: begin
        if (status.disabled) begin
          cmd.sel_zero = 1'b1;
          state_next   = OUT;
        end else if (status.running) begin
          cmd.rd_seg = 1'b1;
          state_next = RD_NEXT;
        end else begin
          cmd.rd_last = 1'b1;
          state_next  = LAST;
        end
      end
      RD_NEXT: begin
        cmd.rd_next   = 1'b1;
        cmd.cap_start = 1'b1;
        state_next    = DIFF;
      end
      DIFF: begin
        cmd.cap_diff = 1'b1;
        state_next   = MUL;
      end
      MUL: begin
        cmd.mul    = 1'b1;
        state_next = DIV;
      end
      DIV: begin
        if (status.div_done) begin
          state_next = FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      FIN: begin
        cmd.finish = 1'b1;
        state_next = OUT;
      end
      LAST: begin
        cmd.cap_last = 1'b1;
        state_next   = OUT;
      end
      OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/plrg_datapath.sv =====
// Datapath of the piecewise linear ramp generator: configuration
// registers, counters, breakpoint memory, multiplier, restoring divider
// and output register. Depends on plrg_pkg and plrg_ram.
`timescale 1ns / 1ps

module plrg_datapath #(
  parameter int MAX_POINTS = plrg_pkg::MAX_POINTS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  plrg_pkg::cmd_t                         cmd,
  output plrg_pkg::status_t                      status,
  input  plrg_pkg::in_word_t                     in_word,
  input  logic                                   cfg_valid,
  input  logic [plrg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [plrg_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output plrg_pkg::out_word_t                    out_word
);

  localparam int V  = plrg_pkg::VALUE_BITS;
  localparam int TB = plrg_pkg::TICK_BITS;
  localparam int CB = plrg_pkg::COUNT_BITS;
  localparam int DB = plrg_pkg::DIV_CNT_BITS;
  localparam int AW = $clog2(MAX_POINTS);

  // Configuration and counters.
  logic [TB-1:0] delta_ticks;
  logic [CB-1:0] num_points;
  logic [CB-1:0] seg;
  logic [TB-1:0] tick;

  // Arithmetic registers.
  logic signed [V-1:0] start_val;
  logic                diff_neg;
  logic [V-1:0]        diff_mag;
  logic [TB-1:0]       div_rem;
  logic [V-1:0]        div_q;
  logic [DB-1:0]       div_cnt;
  logic signed [V-1:0] res_value;
  logic                res_active;

  // Combinational helpers.
  logic [CB-1:0]      n_sat;
  logic [CB-1:0]      n_m1;
  logic               disabled;
  logic [TB:0]        tick_inc;
  logic signed [V:0]  diff;
  logic [V+TB-1:0]    prod;
  logic [TB:0]        trial;
  logic               trial_ge;
  logic signed [V:0]  q_signed;
  logic signed [V:0]  sum;

  // Memory ports.
  logic          ram_wr_en;
  logic [AW-1:0] ram_rd_addr;
  logic          ram_rd_en;
  logic [V-1:0]  ram_rd_data;

  // Point count saturated to the table depth.
  always_comb begin
    if (32'(num_points) > MAX_POINTS) begin
      n_sat = CB'(MAX_POINTS);
    end else begin
      n_sat = num_points;
    end
  end

  assign n_m1     = n_sat - CB'(1);
  assign disabled = (num_points == '0) || (delta_ticks == '0);

  assign status.disabled = disabled;
  assign status.running  = (seg < n_m1);
  assign status.div_done = (div_cnt == DB'(V));
  assign status.out_free = !out_valid || !out_stall;

  // Breakpoint memory: loads write, ticks read one point per cycle.
  assign ram_wr_en = cmd.load && (32'(in_word.point_index) < MAX_POINTS);
  assign ram_rd_en = cmd.rd_seg || cmd.rd_next || cmd.rd_last;

  always_comb begin
    if (cmd.rd_next) begin
      ram_rd_addr = AW'(seg + CB'(1));
    end else if (cmd.rd_last) begin
      ram_rd_addr = AW'(n_m1);
    end else begin
      ram_rd_addr = AW'(seg);
    end
  end

  plrg_ram #(
    .WIDTH (V),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (AW'(in_word.point_index)),
    .wr_data (in_word.point_value),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Arithmetic: difference, product, divider trial and final sum.
  assign tick_inc = {1'b0, tick} + (TB + 1)'(1);
  assign diff     = (V + 1)'($signed(ram_rd_data)) - (V + 1)'(start_val);
  assign prod     = diff_mag * tick;
  assign trial    = {div_rem, div_q[V-1]};
  assign trial_ge = (trial >= {1'b0, delta_ticks});
  assign q_signed = diff_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign sum      = (V + 1)'(start_val) + q_signed;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      delta_ticks <= plrg_pkg::DELTA_TICKS_RESET;
      num_points  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        plrg_pkg::REG_DELTA_TICKS: begin
          delta_ticks <= cfg_data;
        end
        plrg_pkg::REG_NUM_POINTS: begin
          num_points <= cfg_data[CB-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Segment and tick counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      seg  <= '0;
      tick <= '0;
    end else if (cmd.restart) begin
      seg  <= '0;
      tick <= '0;
    end else if (cmd.pre_adjust) begin
      if (!disabled && (tick >= delta_ticks) && (seg < n_m1)) begin
        seg  <= seg + CB'(1);
        tick <= '0;
      end
    end else if (cmd.mul) begin
      if (tick_inc >= {1'b0, delta_ticks}) begin
        seg  <= seg + CB'(1);
        tick <= '0;
      end else begin
        tick <= tick_inc[TB-1:0];
      end
    end
  end

  // Interpolation datapath: sign-magnitude multiply, then restoring divide.
  always_ff @(posedge clk) begin
    if (cmd.cap_start) begin
      start_val <= $signed(ram_rd_data);
    end
    if (cmd.cap_diff) begin
      diff_neg <= diff[V];
      diff_mag <= diff[V] ? V'(-diff) : V'(diff);
    end
    if (cmd.mul) begin
      // The high half is below delta_ticks since tick < delta_ticks.
      div_rem <= prod[V+TB-1:V];
      div_q   <= prod[V-1:0];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_rem <= trial_ge ? TB'(trial - {1'b0, delta_ticks}) : trial[TB-1:0];
      div_q   <= {div_q[V-2:0], trial_ge};
      div_cnt <= div_cnt + DB'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.sel_zero) begin
      res_value  <= '0;
      res_active <= 1'b0;
    end else if (cmd.cap_last) begin
      res_value  <= $signed(ram_rd_data);
      res_active <= 1'b0;
    end else if (cmd.finish) begin
      res_value  <= sum[V-1:0];
      res_active <= 1'b1;
    end
  end

  // Output register: holds the word while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word.value  <= res_value;
      out_word.active <= res_active;
    end
  end

endmodule
